// ===== src/largest_empty_square_finder_assert.svh =====
// Assertion macros for the largest empty square finder checks.
// Each macro samples on the rising edge of clk. NOW and NEXT are off while rst_n is low.
`ifndef LARGEST_EMPTY_SQUARE_FINDER_ASSERT_SVH
`define LARGEST_EMPTY_SQUARE_FINDER_ASSERT_SVH

// Consequent holds in the same cycle as the antecedent.
`define LESF_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lesf check failed: same-cycle rule");

// Consequent holds in the cycle after the antecedent.
`define LESF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lesf check failed: next-cycle rule");

// Consequent holds in the cycle after reset is sampled.
`define LESF_ASSERT_RESET(lbl, cons) \
  lbl: assert property (@(posedge clk) (!rst_n) |=> (cons)) \
    else $error("lesf check failed: reset rule");

`endif

// ===== src/lesf_pkg.sv =====
// ----------------------------------------------------------------------------
// lesf_pkg
// Shared types and constants of the largest empty square finder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lesf_pkg;

  localparam int MAX_ROWS  = 256;
  localparam int MAX_COLS  = 256;
  localparam int MAP_CELLS = MAX_ROWS * MAX_COLS;

  // Configuration register indexes
  localparam logic [2:0] REG_ROWS  = 3'd0;
  localparam logic [2:0] REG_COLS  = 3'd1;
  localparam logic [2:0] REG_EMPTY = 3'd2;
  localparam logic [2:0] REG_OBST  = 3'd3;
  localparam logic [2:0] REG_FILL  = 3'd4;

  typedef enum logic [2:0] {
    ST_CELL_OK  = 3'd0,
    ST_LOAD_OK  = 3'd1,
    ST_MAP_ERR  = 3'd2,
    ST_OUT_CELL = 3'd3,
    ST_NO_DATA  = 3'd4
  } lesf_status_t;

  typedef struct packed {
    logic [8:0] rows;
    logic [8:0] cols;
    logic [7:0] empty_code;
    logic [7:0] obst_code;
    logic [7:0] fill_code;
  } lesf_cfg_t;

  // Classified input item
  typedef struct packed {
    logic mode;
    logic obst;
    logic bad;
  } lesf_cmd_t;

  typedef struct packed {
    lesf_status_t status;
    logic [7:0]   square_row;
    logic [7:0]   square_col;
    logic [8:0]   square_side;
    logic [7:0]   out_byte;
    logic         end_of_row;
    logic         last_cell;
  } lesf_res_t;

  typedef struct packed {
    logic        start;
    logic [15:0] dividend;
    logic [8:0]  divisor;
  } lesf_div_req_t;

  typedef struct packed {
    logic        done;
    logic [15:0] quot;
    logic [8:0]  rem;
  } lesf_div_rsp_t;

endpackage

// ===== src/lesf_front.sv =====
// ----------------------------------------------------------------------------
// lesf_front
// Input side: classifies each cell byte against the codes and queues it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lesf_front (
  input  logic                clk,
  input  logic                rst_n,
  input  lesf_pkg::lesf_cfg_t cfg,
  input  logic                in_push,
  output logic                in_full,
  input  logic                in_mode,
  input  logic [7:0]          in_cell_byte,
  output logic                cmd_valid,
  output lesf_pkg::lesf_cmd_t cmd,
  input  logic                cmd_pop
);
  import lesf_pkg::*;

  lesf_cmd_t  q_r [2];
  lesf_cmd_t  cls;
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push_ok, pop_ok;

  assign in_full   = (cnt_r == 2'd2);
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rp_r];
  assign push_ok   = in_push && !in_full;
  assign pop_ok    = cmd_pop && cmd_valid;

  always_comb begin
    cls.mode = in_mode;
    cls.obst = (in_cell_byte != cfg.empty_code);
    cls.bad  = (in_cell_byte != cfg.empty_code) && (in_cell_byte != cfg.obst_code);
  end

  always_comb begin
    wp_nxt  = push_ok ? ~wp_r : wp_r;
    rp_nxt  = pop_ok ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(push_ok) - 2'(pop_ok);
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      q_r[wp_r] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ===== src/lesf_div.sv =====
// ----------------------------------------------------------------------------
// lesf_div
// Restoring divider, one quotient bit per cycle; maps a read index to row/column.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lesf_div (
  input  logic                    clk,
  input  logic                    rst_n,
  input  lesf_pkg::lesf_div_req_t req,
  output lesf_pkg::lesf_div_rsp_t rsp
);
  import lesf_pkg::*;

  localparam int QW  = 16;
  localparam int CW  = $clog2(QW + 1);

  logic [QW-1:0] q_r, q_nxt;
  logic [8:0]    rem_r, rem_nxt;
  logic [8:0]    dvs_r, dvs_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [9:0]    trial;

  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r, q_r[QW-1]};
    if (req.start) begin
      q_nxt    = req.dividend;
      rem_nxt  = '0;
      dvs_nxt  = req.divisor;
      cnt_nxt  = CW'(QW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // shift in the next dividend bit, subtract when it fits
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = 9'(trial - {1'b0, dvs_r});
        q_nxt   = {q_r[QW-2:0], 1'b1};
      end else begin
        rem_nxt = trial[8:0];
        q_nxt   = {q_r[QW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = q_r;
  assign rsp.rem  = rem_r;

endmodule

// ===== src/lesf_outq.sv =====
// ----------------------------------------------------------------------------
// lesf_outq
// Two-entry result queue between the engine and the result ports.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lesf_outq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                res_push,
  input  lesf_pkg::lesf_res_t res,
  output logic                res_full,
  output logic                out_empty,
  input  logic                out_pop,
  output lesf_pkg::lesf_res_t head
);
  import lesf_pkg::*;

  lesf_res_t  q_r [2];
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push_ok, pop_ok;

  assign res_full  = (cnt_r == 2'd2);
  assign out_empty = (cnt_r == 2'd0);
  assign head      = q_r[rp_r];
  assign push_ok   = res_push && !res_full;
  assign pop_ok    = out_pop && !out_empty;

  always_comb begin
    wp_nxt  = push_ok ? ~wp_r : wp_r;
    rp_nxt  = pop_ok ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(push_ok) - 2'(pop_ok);
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      q_r[wp_r] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ===== src/lesf_back.sv =====
// ----------------------------------------------------------------------------
// lesf_back
// Engine: square-side recurrence over a row buffer, obstacle bitmap, best
// square tracking and read-back rendering.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lesf_back (
  input  logic                    clk,
  input  logic                    rst_n,
  input  lesf_pkg::lesf_cfg_t     cfg,
  input  logic                    cols_wr,
  input  logic                    cmd_valid,
  input  lesf_pkg::lesf_cmd_t     cmd,
  output logic                    cmd_pop,
  output lesf_pkg::lesf_div_req_t div_req,
  input  lesf_pkg::lesf_div_rsp_t div_rsp,
  output logic                    res_push,
  output lesf_pkg::lesf_res_t     res,
  input  logic                    res_full
);
  import lesf_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_LCALC, S_LDONE, S_RDONE, S_DIV, S_PUSH} state_t;
  typedef enum logic [1:0] {PH_LOADING, PH_READY, PH_FINISHED} phase_t;

  function automatic logic [8:0] min3(input logic [8:0] a, input logic [8:0] b,
                                      input logic [8:0] c);
    logic [8:0] m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction

  state_t      st_r, st_nxt;
  phase_t      phase_r, phase_nxt;
  logic [8:0]  left_r, left_nxt;
  logic [8:0]  diag_r, diag_nxt;
  logic [7:0]  lrow_r, lrow_nxt;
  logic [7:0]  lcol_r, lcol_nxt;
  logic [7:0]  btop_r, btop_nxt;
  logic [7:0]  bleft_r, bleft_nxt;
  logic [8:0]  bside_r, bside_nxt;
  logic        bad_r, bad_nxt;
  logic [15:0] ridx_r, ridx_nxt;
  logic [15:0] rrow_r, rrow_nxt;
  logic [7:0]  rcol_r, rcol_nxt;
  logic        stale_r, stale_nxt;
  logic [8:0]  side_r, side_nxt;
  logic        obst_r, obst_nxt;
  logic        badc_r, badc_nxt;
  logic        inside_r, inside_nxt;
  logic [17:0] total_r, total_nxt;
  lesf_res_t   res_r, res_nxt;
  logic        do_clear;

  // memories
  logic        bmap_mem [MAP_CELLS];
  logic [8:0]  side_mem [MAX_COLS];
  logic [8:0]  up_q;
  logic        bm_q;

  // datapath terms
  logic        geo_ok;
  logic [8:0]  up_c, left_c, diag_c, side_c;
  logic [7:0]  top_c, lft_c;
  logic        better;
  logic        row_end, map_end, codes_clash;
  logic        row_over, inside_c;
  logic [9:0]  btop_end, bleft_end;
  logic [17:0] total_c;
  logic        col_end, last_c;

  always_ff @(posedge clk) begin
    if (st_r == S_LCALC) begin
      side_mem[lcol_r]           <= side_c;
      bmap_mem[{lrow_r, lcol_r}] <= obst_r;
    end
    up_q <= side_mem[lcol_r];
    bm_q <= bmap_mem[{rrow_r[7:0], rcol_r}];
  end

  always_comb begin
    geo_ok = (cfg.rows != 9'd0) && (cfg.rows <= 9'(MAX_ROWS)) &&
             (cfg.cols != 9'd0) && (cfg.cols <= 9'(MAX_COLS));

    up_c   = (lrow_r == 8'd0) ? 9'd0 : up_q;
    left_c = (lcol_r == 8'd0) ? 9'd0 : left_r;
    diag_c = (lrow_r == 8'd0 || lcol_r == 8'd0) ? 9'd0 : diag_r;
    side_c = obst_r ? 9'd0 : 9'(min3(up_c, left_c, diag_c) + 9'd1);

    top_c  = 8'(({2'b0, lrow_r} + 10'd1) - {1'b0, side_r});
    lft_c  = 8'(({2'b0, lcol_r} + 10'd1) - {1'b0, side_r});
    better = (side_r != 9'd0) &&
             ((side_r > bside_r) ||
              ((side_r == bside_r) &&
               ((top_c < btop_r) || ((top_c == btop_r) && (lft_c < bleft_r)))));

    row_end     = ({1'b0, lcol_r} + 9'd1) >= cfg.cols;
    map_end     = row_end && (({1'b0, lrow_r} + 9'd1) >= cfg.rows);
    codes_clash = (cfg.empty_code == cfg.obst_code) ||
                  (cfg.empty_code == cfg.fill_code) ||
                  (cfg.obst_code == cfg.fill_code);

    btop_end  = {2'b0, btop_r} + {1'b0, bside_r};
    bleft_end = {2'b0, bleft_r} + {1'b0, bside_r};
    row_over  = rrow_r >= {7'd0, cfg.rows};
    inside_c  = (rrow_r >= {8'd0, btop_r}) && (rrow_r < {6'd0, btop_end}) &&
                (rcol_r >= bleft_r) && ({2'b0, rcol_r} < bleft_end);
    total_c   = {9'd0, cfg.rows} * {9'd0, cfg.cols};

    col_end = ({1'b0, rcol_r} + 9'd1) >= cfg.cols;
    last_c  = ({2'b0, ridx_r} + 18'd1) >= total_r;
  end

  always_comb begin
    st_nxt     = st_r;
    phase_nxt  = phase_r;
    left_nxt   = left_r;
    diag_nxt   = diag_r;
    lrow_nxt   = lrow_r;
    lcol_nxt   = lcol_r;
    btop_nxt   = btop_r;
    bleft_nxt  = bleft_r;
    bside_nxt  = bside_r;
    bad_nxt    = bad_r;
    ridx_nxt   = ridx_r;
    rrow_nxt   = rrow_r;
    rcol_nxt   = rcol_r;
    stale_nxt  = stale_r;
    side_nxt   = side_r;
    obst_nxt   = obst_r;
    badc_nxt   = badc_r;
    inside_nxt = inside_r;
    total_nxt  = total_r;
    res_nxt    = res_r;
    cmd_pop    = 1'b0;
    do_clear   = 1'b0;
    div_req.start = 1'b0;

    unique case (st_r)
      S_IDLE: begin
        if (cmd_valid) begin
          if (!cmd.mode) begin
            if (phase_r != PH_LOADING) begin
              // new map: clear load state, take the byte next cycle
              do_clear  = 1'b1;
              phase_nxt = PH_LOADING;
            end else if (!geo_ok) begin
              cmd_pop        = 1'b1;
              do_clear       = 1'b1;
              phase_nxt      = PH_FINISHED;
              res_nxt        = '0;
              res_nxt.status = ST_MAP_ERR;
              st_nxt         = S_PUSH;
            end else begin
              cmd_pop  = 1'b1;
              obst_nxt = cmd.obst;
              badc_nxt = cmd.bad;
              st_nxt   = S_LCALC;
            end
          end else if (phase_r != PH_READY || !geo_ok) begin
            cmd_pop        = 1'b1;
            res_nxt        = '0;
            res_nxt.status = ST_NO_DATA;
            st_nxt         = S_PUSH;
          end else if (stale_r) begin
            // column count changed: recompute row and column of the read index
            div_req.start = 1'b1;
            st_nxt        = S_DIV;
          end else if (row_over) begin
            cmd_pop        = 1'b1;
            phase_nxt      = PH_FINISHED;
            res_nxt        = '0;
            res_nxt.status = ST_NO_DATA;
            st_nxt         = S_PUSH;
          end else begin
            cmd_pop    = 1'b1;
            inside_nxt = inside_c;
            total_nxt  = total_c;
            st_nxt     = S_RDONE;
          end
        end
      end

      S_LCALC: begin
        diag_nxt = up_c;
        left_nxt = side_c;
        side_nxt = side_c;
        bad_nxt  = bad_r | badc_r;
        st_nxt   = S_LDONE;
      end

      S_LDONE: begin
        if (better) begin
          bside_nxt = side_r;
          btop_nxt  = top_c;
          bleft_nxt = lft_c;
        end
        res_nxt = '0;
        if (!map_end) begin
          if (row_end) begin
            lcol_nxt = 8'd0;
            lrow_nxt = lrow_r + 8'd1;
          end else begin
            lcol_nxt = lcol_r + 8'd1;
          end
          res_nxt.status = ST_CELL_OK;
        end else if (bad_r || codes_clash) begin
          do_clear       = 1'b1;
          phase_nxt      = PH_FINISHED;
          res_nxt.status = ST_MAP_ERR;
        end else begin
          res_nxt.status      = ST_LOAD_OK;
          res_nxt.square_row  = btop_nxt;
          res_nxt.square_col  = bleft_nxt;
          res_nxt.square_side = bside_nxt;
          lrow_nxt  = 8'd0;
          lcol_nxt  = 8'd0;
          ridx_nxt  = 16'd0;
          rrow_nxt  = 16'd0;
          rcol_nxt  = 8'd0;
          stale_nxt = 1'b0;
          phase_nxt = PH_READY;
        end
        st_nxt = S_PUSH;
      end

      S_RDONE: begin
        res_nxt            = '0;
        res_nxt.status     = ST_OUT_CELL;
        res_nxt.out_byte   = inside_r ? cfg.fill_code :
                             (bm_q ? cfg.obst_code : cfg.empty_code);
        res_nxt.end_of_row = col_end;
        res_nxt.last_cell  = last_c;
        if (last_c) begin
          phase_nxt = PH_FINISHED;
        end else begin
          ridx_nxt = ridx_r + 16'd1;
          if (col_end) begin
            rcol_nxt = 8'd0;
            rrow_nxt = rrow_r + 16'd1;
          end else begin
            rcol_nxt = rcol_r + 8'd1;
          end
        end
        st_nxt = S_PUSH;
      end

      S_DIV: begin
        if (div_rsp.done) begin
          rrow_nxt  = div_rsp.quot;
          rcol_nxt  = div_rsp.rem[7:0];
          stale_nxt = 1'b0;
          st_nxt    = S_IDLE;
        end
      end

      S_PUSH: begin
        if (!res_full) begin
          st_nxt = S_IDLE;
        end
      end

      default: begin
        st_nxt = S_IDLE;
      end
    endcase

    if (do_clear) begin
      left_nxt  = 9'd0;
      diag_nxt  = 9'd0;
      lrow_nxt  = 8'd0;
      lcol_nxt  = 8'd0;
      btop_nxt  = 8'd0;
      bleft_nxt = 8'd0;
      bside_nxt = 9'd0;
      bad_nxt   = 1'b0;
      ridx_nxt  = 16'd0;
      rrow_nxt  = 16'd0;
      rcol_nxt  = 8'd0;
      stale_nxt = 1'b0;
    end
    if (cols_wr) begin
      stale_nxt = 1'b1;
    end
  end

  assign div_req.dividend = ridx_r;
  assign div_req.divisor  = cfg.cols;
  assign res_push         = (st_r == S_PUSH) && !res_full;
  assign res              = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= S_IDLE;
      phase_r  <= PH_LOADING;
      left_r   <= 9'd0;
      diag_r   <= 9'd0;
      lrow_r   <= 8'd0;
      lcol_r   <= 8'd0;
      btop_r   <= 8'd0;
      bleft_r  <= 8'd0;
      bside_r  <= 9'd0;
      bad_r    <= 1'b0;
      ridx_r   <= 16'd0;
      rrow_r   <= 16'd0;
      rcol_r   <= 8'd0;
      stale_r  <= 1'b0;
      side_r   <= 9'd0;
      obst_r   <= 1'b0;
      badc_r   <= 1'b0;
      inside_r <= 1'b0;
      total_r  <= 18'd0;
      res_r    <= '0;
    end else begin
      st_r     <= st_nxt;
      phase_r  <= phase_nxt;
      left_r   <= left_nxt;
      diag_r   <= diag_nxt;
      lrow_r   <= lrow_nxt;
      lcol_r   <= lcol_nxt;
      btop_r   <= btop_nxt;
      bleft_r  <= bleft_nxt;
      bside_r  <= bside_nxt;
      bad_r    <= bad_nxt;
      ridx_r   <= ridx_nxt;
      rrow_r   <= rrow_nxt;
      rcol_r   <= rcol_nxt;
      stale_r  <= stale_nxt;
      side_r   <= side_nxt;
      obst_r   <= obst_nxt;
      badc_r   <= badc_nxt;
      inside_r <= inside_nxt;
      total_r  <= total_nxt;
      res_r    <= res_nxt;
    end
  end

endmodule

// ===== src/largest_empty_square_finder.sv =====
// ----------------------------------------------------------------------------
// largest_empty_square_finder
// Loads a map cell by cell, finds the largest all-empty square, reads the map
// back with the square filled.
//
//   channel  handshake            payload
//   in_      in_push / in_full    in_mode, in_cell_byte
//   out_     out_pop / out_empty  out_status, out_square_*, out_byte,
//                                 out_end_of_row, out_last_cell
//   cfg_     cfg_valid/cfg_ready  cfg_index, cfg_data (ready always high)
//
// A loaded cell runs IDLE, LCALC, LDONE, PUSH (a new map adds a clearing IDLE
// pass); a read-back cell runs IDLE, RDONE, PUSH, paced by the registered
// memory read. The first read after a column_count write waits on the divider.
// Two-entry queues on both sides let input and output stall independently.
// Reset is synchronous and clears control state; the memories need no clearing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module largest_empty_square_finder (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  output logic       in_full,
  input  logic       in_mode,
  input  logic [7:0] in_cell_byte,
  output logic       out_empty,
  input  logic       out_pop,
  output logic [2:0] out_status,
  output logic [7:0] out_square_row,
  output logic [7:0] out_square_col,
  output logic [8:0] out_square_side,
  output logic [7:0] out_byte,
  output logic       out_end_of_row,
  output logic       out_last_cell,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [8:0] cfg_data
);
  import lesf_pkg::*;

  logic [8:0]    rows_r, cols_r;
  logic [7:0]    empty_r, obst_r, fill_r;
  lesf_cfg_t     cfg;
  logic          cfg_wr, cols_wr;
  logic          cmd_valid, cmd_pop;
  lesf_cmd_t     cmd;
  lesf_div_req_t div_req;
  lesf_div_rsp_t div_rsp;
  logic          res_push, res_full;
  lesf_res_t     res, head;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign cols_wr   = cfg_wr && (cfg_index == REG_COLS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r  <= 9'd0;
      cols_r  <= 9'd0;
      empty_r <= 8'd46;
      obst_r  <= 8'd111;
      fill_r  <= 8'd120;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        REG_ROWS:  rows_r  <= cfg_data;
        REG_COLS:  cols_r  <= cfg_data;
        REG_EMPTY: empty_r <= cfg_data[7:0];
        REG_OBST:  obst_r  <= cfg_data[7:0];
        REG_FILL:  fill_r  <= cfg_data[7:0];
        default: begin
          // drop writes to unused indexes
        end
      endcase
    end
  end

  always_comb begin
    cfg.rows       = rows_r;
    cfg.cols       = cols_r;
    cfg.empty_code = empty_r;
    cfg.obst_code  = obst_r;
    cfg.fill_code  = fill_r;
  end

  lesf_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg),
    .in_push      (in_push),
    .in_full      (in_full),
    .in_mode      (in_mode),
    .in_cell_byte (in_cell_byte),
    .cmd_valid    (cmd_valid),
    .cmd          (cmd),
    .cmd_pop      (cmd_pop)
  );

  lesf_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  lesf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .cols_wr   (cols_wr),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .div_req   (div_req),
    .div_rsp   (div_rsp),
    .res_push  (res_push),
    .res       (res),
    .res_full  (res_full)
  );

  lesf_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_push  (res_push),
    .res       (res),
    .res_full  (res_full),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .head      (head)
  );

  assign out_status      = head.status;
  assign out_square_row  = head.square_row;
  assign out_square_col  = head.square_col;
  assign out_square_side = head.square_side;
  assign out_byte        = head.out_byte;
  assign out_end_of_row  = head.end_of_row;
  assign out_last_cell   = head.last_cell;

endmodule

// ===== src/lesf_checker.sv =====
// ----------------------------------------------------------------------------
// lesf_checker
// Port-level checks on the result channel of the square finder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "largest_empty_square_finder_assert.svh"

module lesf_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_full,
  input logic       out_empty,
  input logic       out_pop,
  input logic [2:0] out_status,
  input logic [7:0] out_square_row,
  input logic [7:0] out_square_col,
  input logic [8:0] out_square_side,
  input logic [7:0] out_byte,
  input logic       out_end_of_row,
  input logic       out_last_cell
);
  import lesf_pkg::*;

  // a waiting result holds until transfer
  `LESF_ASSERT_NEXT(a_hold_result, !out_empty && !out_pop, !out_empty && $stable(out_status) && $stable(out_square_side) && $stable(out_byte))

  // square fields carry data only with a good load
  `LESF_ASSERT_NOW(a_square_only_load_ok, !out_empty && out_status != ST_LOAD_OK, out_square_row == 8'd0 && out_square_col == 8'd0 && out_square_side == 9'd0)

  // rendered fields carry data only with an output cell
  `LESF_ASSERT_NOW(a_cell_only_out_cell, !out_empty && out_status != ST_OUT_CELL, out_byte == 8'd0 && !out_end_of_row && !out_last_cell)

  // the final cell always closes a row
  `LESF_ASSERT_NOW(a_last_ends_row, !out_empty && out_last_cell, out_end_of_row)

  // reset empties both queues
  `LESF_ASSERT_RESET(a_reset_clears, out_empty && !in_full)

endmodule

bind largest_empty_square_finder lesf_checker u_lesf_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_full         (in_full),
  .out_empty       (out_empty),
  .out_pop         (out_pop),
  .out_status      (out_status),
  .out_square_row  (out_square_row),
  .out_square_col  (out_square_col),
  .out_square_side (out_square_side),
  .out_byte        (out_byte),
  .out_end_of_row  (out_end_of_row),
  .out_last_cell   (out_last_cell)
);

// ===== tb/largest_empty_square_finder_tb.sv =====
// ----------------------------------------------------------------------------
// largest_empty_square_finder_tb
// Self-checking bench for the largest empty square finder. A short directed
// table covers reset, bad geometry, duplicate codes, foreign bytes, maps with
// no empty cell and read-back end cases. Random maps of random geometry and
// codes follow, loaded and read back with gaps on both queues. Every result
// is compared with a cycle-free model of the square search kept in the bench.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module largest_empty_square_finder_tb;
  import lesf_pkg::*;

  localparam int RANDOM_ITEMS = 1850;
  localparam int QUIET_LIMIT  = 2000;
  localparam int END_CYCLES   = 40;

  typedef enum {MAP_LOADING, MAP_READY, MAP_DONE} map_phase_e;
  typedef enum {STEP_CFG, STEP_ITEM} step_kind_e;

  typedef struct {
    step_kind_e kind;
    logic [2:0] idx;
    logic [8:0] data;
    logic       mode;
    logic [7:0] cell_byte;
    bit         typed;
    lesf_res_t  res;
  } dir_step_t;

  logic       clk;
  logic       rst_n;
  logic       in_push;
  logic       in_full;
  logic       in_mode;
  logic [7:0] in_cell_byte;
  logic       out_empty;
  logic       out_pop;
  logic [2:0] out_status;
  logic [7:0] out_square_row;
  logic [7:0] out_square_col;
  logic [8:0] out_square_side;
  logic [7:0] out_byte;
  logic       out_end_of_row;
  logic       out_last_cell;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [2:0] cfg_index;
  logic [8:0] cfg_data;

  largest_empty_square_finder dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_mode         (in_mode),
    .in_cell_byte    (in_cell_byte),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_status      (out_status),
    .out_square_row  (out_square_row),
    .out_square_col  (out_square_col),
    .out_square_side (out_square_side),
    .out_byte        (out_byte),
    .out_end_of_row  (out_end_of_row),
    .out_last_cell   (out_last_cell),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Register copies
  int map_rows, map_cols, empty_code, obst_code, fill_code;

  // Search state
  bit         obst_map [0:MAP_CELLS-1];
  int         side_buf [0:MAX_COLS-1];
  int         left_run, diag_run, cur_row, cur_col;
  int         best_top, best_left, best_side;
  bit         bad_seen;
  int         read_pos;
  map_phase_e map_phase;

  lesf_res_t  pending_results[$];
  dir_step_t  dir_steps[$];

  int errors, items_sent, quiet;
  int loads_ok, map_errs, cells_out, empty_reads, widest_side;
  bit send_gaps_on, pop_gaps_on;
  int pop_hold;

  function automatic int gap_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 20);
    return $urandom_range(30, 80);
  endfunction

  function automatic bit geometry_valid();
    return map_rows >= 1 && map_rows <= MAX_ROWS && map_cols >= 1 && map_cols <= MAX_COLS;
  endfunction

  function automatic void clear_map_state();
    left_run = 0; diag_run = 0;
    cur_row = 0; cur_col = 0;
    best_top = 0; best_left = 0; best_side = 0;
    bad_seen = 1'b0;
    read_pos = 0;
  endfunction

  function automatic void reset_search();
    map_rows = 0; map_cols = 0;
    empty_code = 46; obst_code = 111; fill_code = 120;
    foreach (obst_map[i]) obst_map[i] = 1'b0;
    foreach (side_buf[i]) side_buf[i] = 0;
    clear_map_state();
    map_phase = MAP_LOADING;
  endfunction

  function automatic void apply_register(logic [2:0] idx, logic [8:0] data);
    case (idx)
      REG_ROWS:  map_rows = data;
      REG_COLS:  map_cols = data;
      REG_EMPTY: empty_code = data[7:0];
      REG_OBST:  obst_code = data[7:0];
      REG_FILL:  fill_code = data[7:0];
      default: ;
    endcase
  endfunction

  function automatic lesf_res_t predict_square_step(logic m, logic [7:0] b);
    lesf_res_t res;
    int up, lft, dg, side, top, lcol, total, r, c;
    bit obst, row_end, map_end, in_square;
    res = '0;
    if (!m) begin
      if (map_phase != MAP_LOADING) begin
        clear_map_state();
        map_phase = MAP_LOADING;
      end
      if (!geometry_valid()) begin
        clear_map_state();
        map_phase = MAP_DONE;
        res.status = ST_MAP_ERR;
        return res;
      end
      obst = (b != empty_code);
      if (obst && b != obst_code) bad_seen = 1'b1;
      obst_map[cur_row * MAX_COLS + cur_col] = obst;
      up   = (cur_row == 0) ? 0 : side_buf[cur_col];
      lft  = (cur_col == 0) ? 0 : left_run;
      dg   = (cur_row == 0 || cur_col == 0) ? 0 : diag_run;
      side = up < lft ? up : lft;
      side = obst ? 0 : (side < dg ? side : dg) + 1;
      diag_run = up;
      left_run = side;
      side_buf[cur_col] = side;
      if (side > 0) begin
        top  = cur_row + 1 - side;
        lcol = cur_col + 1 - side;
        if (side > best_side || (side == best_side &&
            (top < best_top || (top == best_top && lcol < best_left)))) begin
          best_side = side;
          best_top  = top;
          best_left = lcol;
        end
      end
      row_end = (cur_col + 1 >= map_cols);
      map_end = row_end && (cur_row + 1 >= map_rows);
      if (!map_end) begin
        if (row_end) begin
          cur_col = 0;
          cur_row++;
        end else begin
          cur_col++;
        end
        res.status = ST_CELL_OK;
        return res;
      end
      if (bad_seen || empty_code == obst_code || empty_code == fill_code ||
          obst_code == fill_code) begin
        clear_map_state();
        map_phase = MAP_DONE;
        res.status = ST_MAP_ERR;
        return res;
      end
      res.status      = ST_LOAD_OK;
      res.square_row  = 8'(best_top);
      res.square_col  = 8'(best_left);
      res.square_side = 9'(best_side);
      cur_row = 0; cur_col = 0;
      read_pos = 0;
      map_phase = MAP_READY;
      return res;
    end
    if (map_phase != MAP_READY || !geometry_valid()) begin
      res.status = ST_NO_DATA;
      return res;
    end
    total = map_rows * map_cols;
    r = read_pos / map_cols;
    c = read_pos % map_cols;
    if (r >= map_rows) begin
      map_phase = MAP_DONE;
      res.status = ST_NO_DATA;
      return res;
    end
    in_square = r >= best_top && r < best_top + best_side &&
                c >= best_left && c < best_left + best_side;
    res.status     = ST_OUT_CELL;
    res.out_byte   = in_square ? 8'(fill_code) :
                     (obst_map[r * MAX_COLS + c] ? 8'(obst_code) : 8'(empty_code));
    res.end_of_row = (c + 1 >= map_cols);
    res.last_cell  = (read_pos + 1 >= total);
    if (read_pos + 1 >= total) map_phase = MAP_DONE;
    else read_pos++;
    return res;
  endfunction

  // A geometry write must never expose map or row buffer entries never written
  function automatic bit geometry_safe(int nr, int nc);
    if (map_phase == MAP_DONE) return 1'b1;
    if (map_phase == MAP_LOADING) return cur_row == 0 && cur_col == 0;
    return nr <= map_rows && nc <= map_cols;
  endfunction

  function automatic logic [7:0] pick_cell(int dens, int noise_pm, bit is_last);
    if (dens >= 100 && is_last) return 8'(empty_code);
    if ($urandom_range(0, 999) < noise_pm) return 8'($urandom_range(0, 255));
    return ($urandom_range(0, 99) < dens) ? 8'(obst_code) : 8'(empty_code);
  endfunction

  function automatic void add_cfg(logic [2:0] idx, logic [8:0] data);
    dir_step_t s;
    s = '{kind: STEP_CFG, idx: idx, data: data, mode: 1'b0, cell_byte: 8'h00,
          typed: 1'b0, res: '0};
    dir_steps.push_back(s);
  endfunction

  function automatic void add_cell(logic m, logic [7:0] b);
    dir_step_t s;
    s = '{kind: STEP_ITEM, idx: REG_ROWS, data: 9'h000, mode: m, cell_byte: b,
          typed: 1'b0, res: '0};
    dir_steps.push_back(s);
  endfunction

  function automatic void add_typed(logic m, logic [7:0] b, lesf_status_t st, int row,
                                    int col, int side, int ob, int eor, int is_last);
    dir_step_t s;
    s = '{kind: STEP_ITEM, idx: REG_ROWS, data: 9'h000, mode: m, cell_byte: b,
          typed: 1'b1, res: '0};
    s.res.status      = st;
    s.res.square_row  = 8'(row);
    s.res.square_col  = 8'(col);
    s.res.square_side = 9'(side);
    s.res.out_byte    = 8'(ob);
    s.res.end_of_row  = 1'(eor);
    s.res.last_cell   = 1'(is_last);
    dir_steps.push_back(s);
  endfunction

  function automatic void build_directed();
    // Read before any map, then loads with zero and oversized geometry
    add_typed(1'b1, 8'hFF, ST_NO_DATA, 0, 0, 0, 0, 0, 0);
    add_typed(1'b0, 8'd46, ST_MAP_ERR, 0, 0, 0, 0, 0, 0);
    add_cfg(REG_ROWS, 9'd257);
    add_cfg(REG_COLS, 9'd2);
    add_typed(1'b0, 8'd46, ST_MAP_ERR, 0, 0, 0, 0, 0, 0);
    add_cfg(REG_ROWS, 9'd2);
    // All-empty 2x2: whole map is the square
    add_typed(1'b0, 8'd46, ST_CELL_OK, 0, 0, 0, 0, 0, 0);
    add_typed(1'b0, 8'd46, ST_CELL_OK, 0, 0, 0, 0, 0, 0);
    add_typed(1'b0, 8'd46, ST_CELL_OK, 0, 0, 0, 0, 0, 0);
    add_typed(1'b0, 8'd46, ST_LOAD_OK, 0, 0, 2, 0, 0, 0);
    add_typed(1'b1, 8'h00, ST_OUT_CELL, 0, 0, 0, 120, 0, 0);
    add_typed(1'b1, 8'h00, ST_OUT_CELL, 0, 0, 0, 120, 1, 0);
    add_typed(1'b1, 8'h00, ST_OUT_CELL, 0, 0, 0, 120, 0, 0);
    add_typed(1'b1, 8'h00, ST_OUT_CELL, 0, 0, 0, 120, 1, 1);
    add_typed(1'b1, 8'h00, ST_NO_DATA, 0, 0, 0, 0, 0, 0);
    // Map with no empty cell, started fresh after the read-back
    add_cell(1'b0, 8'd111);
    add_cell(1'b0, 8'd111);
    add_cell(1'b0, 8'd111);
    add_typed(1'b0, 8'd111, ST_LOAD_OK, 0, 0, 0, 0, 0, 0);
    add_cell(1'b1, 8'h00);
    add_cell(1'b1, 8'h00);
    // Fill code equal to the empty code, extreme code values
    add_cfg(REG_EMPTY, 9'd0);
    add_cfg(REG_OBST, 9'd255);
    add_cfg(REG_FILL, 9'd0);
    add_cell(1'b0, 8'd255);
    add_cell(1'b0, 8'd0);
    add_cell(1'b0, 8'd0);
    add_typed(1'b0, 8'd0, ST_MAP_ERR, 0, 0, 0, 0, 0, 0);
    // Foreign byte poisons the map; bit 8 of a code write is dropped
    add_cfg(REG_FILL, 9'h17F);
    add_cell(1'b0, 8'h5A);
    add_cell(1'b0, 8'd0);
    add_cell(1'b0, 8'd0);
    add_typed(1'b0, 8'd0, ST_MAP_ERR, 0, 0, 0, 0, 0, 0);
    add_typed(1'b1, 8'h00, ST_NO_DATA, 0, 0, 0, 0, 0, 0);
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [8:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_register(idx, data);
  endtask

  task automatic send_item(logic m, logic [7:0] b, bit typed, lesf_res_t want);
    lesf_res_t res;
    int gap;
    if (send_gaps_on && $urandom_range(0, 3) == 0) begin
      gap = gap_cycles();
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push      <= 1'b1;
    in_mode      <= m;
    in_cell_byte <= b;
    @(posedge clk);
    while (in_full) @(posedge clk);
    res = predict_square_step(m, b);
    pending_results.push_back(typed ? want : res);
    items_sent++;
  endtask

  // Hold both request lines low and wait for every pending result
  task automatic drain();
    in_push   <= 1'b0;
    cfg_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_codes();
    int e, o, f;
    e = $urandom_range(0, 255);
    do o = $urandom_range(0, 255); while (o == e);
    do f = $urandom_range(0, 255); while (f == e || f == o);
    if ($urandom_range(0, 9) == 0) begin
      case ($urandom_range(0, 2))
        0: o = e;
        1: f = e;
        default: f = o;
      endcase
    end
    write_reg(REG_EMPTY, {1'($urandom_range(0, 1)), 8'(e)});
    write_reg(REG_OBST, {1'($urandom_range(0, 1)), 8'(o)});
    write_reg(REG_FILL, {1'($urandom_range(0, 1)), 8'(f)});
  endtask

  task automatic run_episode(int ep);
    int nr, nc, r, cells, dens, noise_pm, kind, load_n, read_n, i;
    bit chg_geo, chg_codes, big;
    send_gaps_on = ($urandom_range(0, 3) != 0);
    pop_gaps_on  = ($urandom_range(0, 3) != 0);
    big = 1'b0;
    nr = map_rows;
    nc = map_cols;
    chg_geo = ep == 0 || ep == 2 || ep == 5 || !geometry_valid() ||
              map_rows * map_cols >= 256 || $urandom_range(0, 99) < 35;
    chg_codes = ep == 0 || $urandom_range(0, 99) < 25;
    if (chg_geo) begin
      r = $urandom_range(0, 99);
      if (ep == 2) begin
        nr = MAX_ROWS; nc = 1; big = 1'b1;
      end else if (ep == 5) begin
        nr = 1; nc = MAX_COLS; big = 1'b1;
      end else if (r < 3) begin
        big = 1'b1;
        if ($urandom_range(0, 1)) begin
          nr = MAX_ROWS; nc = $urandom_range(1, 2);
        end else begin
          nr = $urandom_range(1, 2); nc = MAX_COLS;
        end
      end else if (r < 9) begin
        nr = $urandom_range(1, 6);
        nc = $urandom_range(1, 6);
        case ($urandom_range(0, 2))
          0: nr = 0;
          1: nc = 0;
          default: if ($urandom_range(0, 1)) nr = $urandom_range(257, 511);
                   else nc = $urandom_range(257, 511);
        endcase
      end else begin
        nr = $urandom_range(1, 6);
        nc = $urandom_range(1, 7);
      end
    end
    if (chg_geo || chg_codes) begin
      drain();
      if (chg_geo) begin
        if (!geometry_safe(nr, nc)) begin
          // Abort the current map through a bad-geometry load first
          write_reg(REG_ROWS, 9'd0);
          drain();
          send_item(1'b0, 8'($urandom_range(0, 255)), 1'b0, '0);
          drain();
        end
        write_reg(REG_ROWS, 9'(nr));
        write_reg(REG_COLS, 9'(nc));
      end
      if (chg_codes) write_codes();
      drain();
    end
    if (!geometry_valid()) begin
      repeat ($urandom_range(1, 4))
        send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), 1'b0, '0);
      return;
    end
    cells    = map_rows * map_cols;
    noise_pm = big ? 0 : (($urandom_range(0, 2) == 0) ? 30 : 0);
    case ($urandom_range(0, 4))
      0: dens = 0;
      1: dens = 15;
      2: dens = 40;
      3: dens = 75;
      default: dens = 100;
    endcase
    if (big) dens = 100;
    kind = $urandom_range(0, 99);
    if (kind < 70) begin
      load_n = cells;
      read_n = cells + $urandom_range(0, 1);
    end else if (kind < 82) begin
      load_n = cells;
      read_n = $urandom_range(0, cells - 1);
    end else if (kind < 94) begin
      load_n = $urandom_range(1, cells);
      read_n = $urandom_range(0, 2);
    end else begin
      repeat ($urandom_range(1, 8))
        send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), 1'b0, '0);
      return;
    end
    for (i = 0; i < load_n; i++)
      send_item(1'b0, pick_cell(dens, noise_pm, i == cells - 1), 1'b0, '0);
    if ($urandom_range(0, 19) == 0) drain();
    for (i = 0; i < read_n; i++)
      send_item(1'b1, 8'($urandom_range(0, 255)), 1'b0, '0);
  endtask

  function automatic void check_field(string name, logic [8:0] want, logic [8:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  // Result side: compare each transfer with the oldest expectation
  always @(posedge clk) begin : result_check
    lesf_res_t want;
    if (rst_n && out_pop && !out_empty) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected, expected none, got status %0d",
                 $time, out_status);
      end else begin
        want = pending_results.pop_front();
        check_field("status", want.status, out_status);
        check_field("square_row", want.square_row, out_square_row);
        check_field("square_col", want.square_col, out_square_col);
        check_field("square_side", want.square_side, out_square_side);
        check_field("out_byte", want.out_byte, out_byte);
        check_field("end_of_row", want.end_of_row, out_end_of_row);
        check_field("last_cell", want.last_cell, out_last_cell);
        case (want.status)
          ST_LOAD_OK: begin
            loads_ok++;
            if (want.square_side > widest_side) widest_side = want.square_side;
          end
          ST_MAP_ERR:  map_errs++;
          ST_OUT_CELL: cells_out++;
          ST_NO_DATA:  empty_reads++;
          default: ;
        endcase
      end
    end
  end

  // Result side stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
      pop_hold = 0;
    end else if (pop_hold > 0) begin
      pop_hold--;
      out_pop <= 1'b0;
    end else begin
      out_pop <= 1'b1;
      if (pop_gaps_on && $urandom_range(0, 3) == 0) pop_hold = gap_cycles();
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty) ||
        (cfg_valid && cfg_ready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("%0t: no transfer for %0d cycles, %0d results pending", $time, quiet,
                 pending_results.size());
        $display("[largest_empty_square_finder] ERROR");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int ep, dir_items;
    step_kind_e prev_kind;
    rst_n        = 1'b0;
    in_push      = 1'b0;
    in_mode      = 1'b0;
    in_cell_byte = 8'h00;
    cfg_valid    = 1'b0;
    cfg_index    = REG_ROWS;
    cfg_data     = 9'h000;
    send_gaps_on = 1'b0;
    pop_gaps_on  = 1'b1;
    errors = 0; items_sent = 0; quiet = 0;
    loads_ok = 0; map_errs = 0; cells_out = 0; empty_reads = 0; widest_side = 0;
    reset_search();
    build_directed();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    prev_kind = STEP_ITEM;
    foreach (dir_steps[i]) begin
      if (dir_steps[i].kind != prev_kind) drain();
      prev_kind = dir_steps[i].kind;
      if (dir_steps[i].kind == STEP_CFG)
        write_reg(dir_steps[i].idx, dir_steps[i].data);
      else
        send_item(dir_steps[i].mode, dir_steps[i].cell_byte, dir_steps[i].typed,
                  dir_steps[i].res);
    end
    drain();
    dir_items = items_sent;

    ep = 0;
    while (items_sent - dir_items < RANDOM_ITEMS) begin
      run_episode(ep);
      ep++;
    end
    drain();
    repeat (END_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      errors++;
      $display("%0t: %0d results never arrived", $time, pending_results.size());
    end

    $display("%0d items over %0d random maps: %0d squares found (widest %0d), %0d map errors",
             items_sent, ep, loads_ok, widest_side, map_errs);
    $display("%0d cells read back, %0d reads with no data, %0d mismatches",
             cells_out, empty_reads, errors);
    if (errors == 0) begin
      $display("[largest_empty_square_finder] OK");
    end else begin
      $display("[largest_empty_square_finder] ERROR");
    end
    $finish;
  end

endmodule
